[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl, clocked on aclk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition must never be true at a clock edge out of reset
`define SPQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// package for the slot pool: sizes, codes, word types and state encoding
package spq_pkg;

    localparam int SLOTS     = 1024;
    localparam int GROUPS    = 64;
    localparam int IDX_W     = 10;
    localparam int GRP_W     = 6;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int USAGE_W   = 11;
    localparam int LIMIT_W   = 11;
    localparam logic [USAGE_W-1:0] USAGE_MAX   = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NO_GROUP_SLOT = 2'd1,
        ST_NO_FREE_SLOT  = 2'd2,
        ST_LIST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_UNCOUNT
    } fsm_t;

    typedef struct packed {
        logic             command;
        logic             group_valid;
        logic [GRP_W-1:0] group_id;
        logic [IDX_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] granted_slot;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [GRP_W-1:0] id;
    } owner_t;

endpackage

[rtl/core/slot_pool_with_group_quota.sv]
// slot pool top level: fifo free list of slots with a per-group quota
//
// input words on s_item (valid/ready) either allocate a slot, optionally for a
// quota group, or release a slot back to the tail of the free list. every word
// gives exactly one result word on m_item (valid/ready): a status and, on a
// successful allocate, the granted slot.
// the result word is written into the output register from the S_EXEC state that follows
// acceptance, and the block takes no new word until that is done. a release of a slot
// that carries a group record then counts the group down in the S_UNCOUNT state before
// the next word is taken. the free list, owner and usage memories are read through a
// registered read port and then written back.
// group_limit (limit_reg) is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce; reset sets it to 1024.
// after reset the owner memory is swept once, one slot per cycle, so s_ready
// stays low until the sweep is done. the free list needs no sweep: entries never
// written read as their own position.
// the result is held in an output register; if m_ready is low the word waits
// there, the next input word is still accepted, and its processing holds
// until the output register frees up.
module slot_pool_with_group_quota
    import spq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item
);

`include "assert_macros.svh"

    // memories
    logic [IDX_W-1:0]   fq_mem [SLOTS];
    owner_t             own_mem [SLOTS];
    logic [USAGE_W-1:0] us_mem [GROUPS];

    logic               fq_we;
    logic [IDX_W-1:0]   fq_waddr;
    logic [IDX_W-1:0]   fq_wdata;
    logic [IDX_W-1:0]   fq_rdata;

    logic               own_we;
    logic [IDX_W-1:0]   own_waddr;
    owner_t             own_wdata;
    logic [IDX_W-1:0]   own_raddr;
    owner_t             own_rdata;

    logic               us_we;
    logic [GRP_W-1:0]   us_waddr;
    logic [USAGE_W-1:0] us_wdata;
    logic [GRP_W-1:0]   us_raddr;
    logic [USAGE_W-1:0] us_rdata;

    // control state
    fsm_t               state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic               wrap_reg, wrap_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [GROUPS-1:0]  us_valid_reg, us_valid_next;
    logic [GRP_W-1:0]   us_raddr_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg, out_valid_next;
    in_item_t           item_reg, item_next;
    out_item_t          out_reg, out_next;

    logic               can_emit;
    logic               fq_written;
    logic [IDX_W-1:0]   grant_slot;
    logic [USAGE_W-1:0] usage_cur;
    logic               grouped;
    logic               slot_in_range;

    always_ff @(posedge aclk) begin
        if (fq_we) begin
            fq_mem[fq_waddr] <= fq_wdata;
        end
        fq_rdata <= fq_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[own_waddr] <= own_wdata;
        end
        own_rdata <= own_mem[own_raddr];
    end

    always_ff @(posedge aclk) begin
        if (us_we) begin
            us_mem[us_waddr] <= us_wdata;
        end
        us_rdata <= us_mem[us_raddr];
    end

    // positions of the ring not yet written on the first lap still hold their own index
    assign fq_written = wrap_reg || (head_reg < tail_reg);
    assign grant_slot = fq_written ? fq_rdata : head_reg;
    assign usage_cur  = us_valid_reg[us_raddr_reg] ? us_rdata : '0;
    assign grouped    = item_reg.group_valid
                        && ((GRP_W + 1)'(item_reg.group_id) < (GRP_W + 1)'(GROUPS));
    assign slot_in_range = CNT_W'(item_reg.slot_index) < CNT_W'(SLOTS);
    assign can_emit   = !out_valid_reg || m_ready;

    assign own_raddr = (state_reg == S_IDLE) ? s_item.slot_index : item_reg.slot_index;

    always_comb begin
        case (state_reg)
            S_IDLE:  us_raddr = s_item.group_id;
            S_EXEC:  us_raddr = (item_reg.command == CMD_ALLOC) ? item_reg.group_id
                                                                : own_rdata.id;
            default: us_raddr = us_raddr_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wrap_next      = wrap_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        us_valid_next  = us_valid_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;

        fq_we     = 1'b0;
        fq_waddr  = tail_reg;
        fq_wdata  = item_reg.slot_index;
        own_we    = 1'b0;
        own_waddr = clr_reg;
        own_wdata = '0;
        us_we     = 1'b0;
        us_waddr  = us_raddr_reg;
        us_wdata  = usage_cur;

        case (state_reg)
            S_CLEAR: begin
                own_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                if (can_emit) begin
                    out_valid_next      = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.granted_slot = '0;
                    state_next          = S_IDLE;
                    if (item_reg.command == CMD_ALLOC) begin
                        if (grouped && (usage_cur >= USAGE_W'(limit_reg))) begin
                            out_next.status = ST_NO_GROUP_SLOT;
                        end else if (count_reg == '0) begin
                            out_next.status = ST_NO_FREE_SLOT;
                        end else begin
                            out_next.granted_slot = grant_slot;
                            head_next  = (head_reg == IDX_W'(SLOTS - 1)) ? '0
                                                                         : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            if (grouped) begin
                                own_we          = 1'b1;
                                own_waddr       = grant_slot;
                                own_wdata.valid = 1'b1;
                                own_wdata.id    = item_reg.group_id;
                                us_we           = 1'b1;
                                us_waddr        = item_reg.group_id;
                                us_wdata        = (usage_cur == USAGE_MAX) ? usage_cur
                                                                           : usage_cur + 1'b1;
                                us_valid_next[item_reg.group_id] = 1'b1;
                            end
                        end
                    end else if (slot_in_range) begin
                        if (count_reg >= CNT_W'(SLOTS)) begin
                            out_next.status = ST_LIST_FULL;
                        end else begin
                            fq_we      = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (tail_reg == IDX_W'(SLOTS - 1)) begin
                                tail_next = '0;
                                wrap_next = 1'b1;
                            end else begin
                                tail_next = tail_reg + 1'b1;
                            end
                            if (own_rdata.valid) begin
                                // drop the record, the group is counted down next cycle
                                own_we     = 1'b1;
                                own_waddr  = item_reg.slot_index;
                                own_wdata  = '0;
                                state_next = S_UNCOUNT;
                            end
                        end
                    end
                end
            end

            S_UNCOUNT: begin
                us_we    = 1'b1;
                us_waddr = us_raddr_reg;
                us_wdata = (usage_cur == '0) ? usage_cur : usage_cur - 1'b1;
                us_valid_next[us_raddr_reg] = 1'b1;
                state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            head_reg      <= '0;
            tail_reg      <= '0;
            wrap_reg      <= 1'b0;
            count_reg     <= CNT_W'(SLOTS);
            clr_reg       <= '0;
            us_valid_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrap_reg      <= wrap_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            us_valid_reg  <= us_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        out_reg      <= out_next;
        us_raddr_reg <= us_raddr;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    `SPQ_NEVER(a_count_bound, count_reg > CNT_W'(SLOTS), "free count above pool size")
    `SPQ_NEVER(a_ready_in_clear, (state_reg == S_CLEAR) && s_ready, "input taken during sweep")
    `SPQ_ASSERT(a_accept_exec, (s_valid && s_ready) |=> (state_reg == S_EXEC),
                "accepted word not processed")
    `SPQ_ASSERT(a_uncount_after_exec, (state_reg == S_UNCOUNT) |-> ($past(state_reg) == S_EXEC),
                "group count-down without a release")

endmodule

[tb/tb_top.sv]
// testbench for the slot pool: directed and random words checked against a local pool predictor
module tb_top
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_item;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_item;

    slot_pool_with_group_quota i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // pool predictor state
    logic [IDX_W-1:0]   ring_slots [SLOTS];
    int unsigned        ring_rd;
    int unsigned        ring_wr;
    int unsigned        free_count;
    owner_t             slot_owner [SLOTS];
    logic [USAGE_W-1:0] grp_usage [GROUPS];
    logic [LIMIT_W-1:0] quota_limit;

    out_item_t          pending_results [$];
    logic [IDX_W-1:0]   held_slots [$];
    int unsigned        err_count = 0;
    int unsigned        stall_left = 0;
    bit                 idle_on;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic void pool_reset();
        for (int i = 0; i < SLOTS; i++) begin
            ring_slots[i] = IDX_W'(i);
            slot_owner[i] = '0;
        end
        for (int g = 0; g < GROUPS; g++) begin
            grp_usage[g] = '0;
        end
        ring_rd     = 0;
        ring_wr     = 0;
        free_count  = SLOTS;
        quota_limit = LIMIT_RESET;
    endfunction

    // predicted result of one word, with the pool state moved on
    function automatic out_item_t pool_apply(input in_item_t w);
        out_item_t        r;
        logic [IDX_W-1:0] s;
        logic [GRP_W-1:0] g;
        r.status       = ST_OK;
        r.granted_slot = '0;
        if (w.command == CMD_ALLOC) begin
            if (w.group_valid && grp_usage[w.group_id] >= quota_limit) begin
                r.status = ST_NO_GROUP_SLOT;
            end else if (free_count == 0) begin
                r.status = ST_NO_FREE_SLOT;
            end else begin
                s = ring_slots[ring_rd];
                ring_rd = (ring_rd + 1) % SLOTS;
                free_count--;
                r.granted_slot = s;
                // an ungrouped grant leaves any old owner record in place
                if (w.group_valid) begin
                    slot_owner[s].valid = 1'b1;
                    slot_owner[s].id    = w.group_id;
                    if (grp_usage[w.group_id] != USAGE_MAX) begin
                        grp_usage[w.group_id]++;
                    end
                end
            end
        end else if (free_count >= SLOTS) begin
            r.status = ST_LIST_FULL;
        end else begin
            ring_slots[ring_wr] = w.slot_index;
            ring_wr = (ring_wr + 1) % SLOTS;
            free_count++;
            if (slot_owner[w.slot_index].valid) begin
                g = slot_owner[w.slot_index].id;
                slot_owner[w.slot_index] = '0;
                if (grp_usage[g] != '0) begin
                    grp_usage[g]--;
                end
            end
        end
        return r;
    endfunction

    function automatic in_item_t word_of(input logic cmd, input logic gv,
                                         input logic [GRP_W-1:0] gid,
                                         input logic [IDX_W-1:0] slot);
        return in_item_t'{cmd, gv, gid, slot};
    endfunction

    function automatic in_item_t random_word(input int unsigned alloc_pct,
                                             input int unsigned grp_top);
        in_item_t    w;
        int unsigned pick;
        w.group_valid = 1'($urandom_range(0, 1));
        w.group_id    = GRP_W'($urandom_range(0, GROUPS - 1));
        w.slot_index  = IDX_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(1, 100) <= alloc_pct) begin
            w.command     = CMD_ALLOC;
            w.group_valid = ($urandom_range(0, 9) < 7);
            w.group_id    = GRP_W'($urandom_range(0, grp_top));
        end else begin
            w.command = CMD_RELEASE;
            // mostly hand back a slot that is out, else a random one
            if (held_slots.size() != 0 && $urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, held_slots.size() - 1);
                w.slot_index = held_slots[pick];
                held_slots.delete(pick);
            end
        end
        return w;
    endfunction

    // drive one word, wait for its handshake, queue its predicted result
    task automatic send_word(input in_item_t w);
        out_item_t r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = pool_apply(w);
        pending_results = {pending_results, r};
        if (w.command == CMD_ALLOC && r.status == ST_OK) begin
            held_slots = {held_slots, r.granted_slot};
        end
    endtask

    // let every result drain, then the trailing group count-down
    task automatic wait_idle(input int unsigned settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle(4);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        quota_limit = v;
    endtask

    task automatic run_random(input int unsigned n, input int unsigned alloc_pct,
                              input int unsigned grp_top);
        repeat (n) send_word(random_word(alloc_pct, grp_top));
    endtask

    // pool starts full: releases bounce, owner record survives a bounced release
    task automatic test_full_list();
        send_word(word_of(CMD_RELEASE, 1'b1, 6'd63, 10'd1023));
        send_word(word_of(CMD_ALLOC, 1'b0, 6'd63, 10'd1023));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd0, 10'd0));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd63, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd1000));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd999));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd1));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd0, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd1));
    endtask

    task automatic test_quota_limits();
        write_limit(LIMIT_W'(1));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd5, 10'd0));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd5, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, held_slots.pop_back()));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd5, 10'd0));
        write_limit(LIMIT_W'(0));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd6, 10'd0));
        send_word(word_of(CMD_ALLOC, 1'b0, 6'd6, 10'd0));
    endtask

    task automatic test_mixed_traffic();
        write_limit(LIMIT_W'(1024));
        run_random(200, 70, GROUPS - 1);
    endtask

    task automatic test_tight_quota();
        repeat (4) begin
            write_limit(LIMIT_W'($urandom_range(1, 4)));
            run_random(40, 60, 7);
        end
    endtask

    task automatic test_zero_quota();
        write_limit(LIMIT_W'(0));
        run_random(40, 70, GROUPS - 1);
    endtask

    task automatic test_drain_pool();
        write_limit(LIMIT_W'(2047));
        while (free_count != 0) send_word(random_word(98, GROUPS - 1));
    endtask

    // empty pool: two copies of one slot come back to back off the list
    task automatic test_stale_record();
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd9, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd777));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd777));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd9, 10'd0));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd10, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd777));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd777));
        send_word(word_of(CMD_ALLOC, 1'b1, 6'd11, 10'd0));
        send_word(word_of(CMD_ALLOC, 1'b0, 6'd0, 10'd0));
        send_word(word_of(CMD_RELEASE, 1'b0, 6'd0, 10'd777));
    endtask

    task automatic test_near_empty();
        repeat (2) begin
            write_limit(LIMIT_W'($urandom_range(2, 40)));
            run_random(60, 50, 15);
        end
    endtask

    task automatic test_no_idle_tail();
        write_limit(LIMIT_RESET);
        idle_on = 1'b0;
        run_random(80, 50, GROUPS - 1);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t unexpected result word: expected none, actual status %0d slot %0d",
                         $time, m_item.status, m_item.granted_slot);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_item.status !== want.status) begin
                    err_count++;
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_item.status);
                end
                if (m_item.granted_slot !== want.granted_slot) begin
                    err_count++;
                    $display("%0t granted_slot mismatch: expected %0d, actual %0d",
                             $time, want.granted_slot, m_item.granted_slot);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        idle_on     = 1'b1;
        pool_reset();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_item      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_full_list();
        test_quota_limits();
        test_mixed_traffic();
        test_tight_quota();
        test_zero_quota();
        test_drain_pool();
        test_stale_record();
        test_near_empty();
        test_no_idle_tail();

        wait_idle(8);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

[slot_pool_with_group_quota.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/slot_pool_with_group_quota.sv
tb/tb_top.sv
